>>> sv/astc_unquantize_endpoint_weight_top_defines.svh
// assertion macros shared by the checker of the astc unquantize block
// no dependencies; included by files that hold concurrent assertions
`ifndef ASTC_UNQUANTIZE_ENDPOINT_WEIGHT_TOP_DEFINES_SVH
`define ASTC_UNQUANTIZE_ENDPOINT_WEIGHT_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define ASTCUQ_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define ASTCUQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/astcuq_pkg.sv
// types, range tables and decode functions for the astc unquantize pipeline
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package astcuq_pkg;

   // encoding of a quantization range
   typedef enum logic [1:0] {
      KIND_BITS  = 2'd0,
      KIND_TRIT  = 2'd1,
      KIND_QUINT = 2'd2
   } kind_type;

   // command codes
   localparam logic CMD_ENDPOINT = 1'b0;
   localparam logic CMD_WEIGHT   = 1'b1;

   typedef struct packed {
      logic [7:0] top;
      kind_type   kind;
      logic [3:0] nbits;
   } range_type;

   localparam int EpCount = 17;
   localparam int WtCount = 12;
   localparam logic [7:0] WtTopMax = 8'd31;

   localparam range_type EP_RANGES [EpCount] = '{
      '{8'd5,   KIND_TRIT,  4'd1}, '{8'd7,   KIND_BITS,  4'd3}, '{8'd9,   KIND_QUINT, 4'd1},
      '{8'd11,  KIND_TRIT,  4'd2}, '{8'd15,  KIND_BITS,  4'd4}, '{8'd19,  KIND_QUINT, 4'd2},
      '{8'd23,  KIND_TRIT,  4'd3}, '{8'd31,  KIND_BITS,  4'd5}, '{8'd39,  KIND_QUINT, 4'd3},
      '{8'd47,  KIND_TRIT,  4'd4}, '{8'd63,  KIND_BITS,  4'd6}, '{8'd79,  KIND_QUINT, 4'd4},
      '{8'd95,  KIND_TRIT,  4'd5}, '{8'd127, KIND_BITS,  4'd7}, '{8'd159, KIND_QUINT, 4'd5},
      '{8'd191, KIND_TRIT,  4'd6}, '{8'd255, KIND_BITS,  4'd8}
   };

   localparam range_type WT_RANGES [WtCount] = '{
      '{8'd1,  KIND_BITS,  4'd1}, '{8'd2,  KIND_TRIT,  4'd0}, '{8'd3,  KIND_BITS,  4'd2},
      '{8'd4,  KIND_QUINT, 4'd0}, '{8'd5,  KIND_TRIT,  4'd1}, '{8'd7,  KIND_BITS,  4'd3},
      '{8'd9,  KIND_QUINT, 4'd1}, '{8'd11, KIND_TRIT,  4'd2}, '{8'd15, KIND_BITS,  4'd4},
      '{8'd19, KIND_QUINT, 4'd2}, '{8'd23, KIND_TRIT,  4'd3}, '{8'd31, KIND_BITS,  4'd5}
   };

   localparam logic [7:0] WT_TRIT_DIRECT  [3] = '{8'd0, 8'd32, 8'd63};
   localparam logic [7:0] WT_QUINT_DIRECT [5] = '{8'd0, 8'd16, 8'd32, 8'd47, 8'd63};

   // after range selection
   typedef struct packed {
      logic       weight;
      logic       invalid;
      logic [7:0] q;
      logic [7:0] top;
      kind_type   kind;
      logic [3:0] nbits;
   } sel_type;

   // after split into digit and low bits
   typedef struct packed {
      logic       weight;
      logic       invalid;
      logic       direct;
      logic [7:0] direct_val;
      logic [2:0] d;
      logic [8:0] a;
      logic [8:0] b;
      logic [7:0] c;
   } dec_type;

   // after the multiply-add
   typedef struct packed {
      logic       weight;
      logic       invalid;
      logic [7:0] value;
   } mid_type;

   // largest supported range not above the request
   function automatic sel_type select_range(logic weight, logic [7:0] req, logic [7:0] q);
      sel_type    r;
      logic       found;
      logic [7:0] req_c;
      range_type  e;
      found = 1'b0;
      e     = '{8'd0, KIND_BITS, 4'd0};
      req_c = (weight == CMD_WEIGHT && req > WtTopMax) ? WtTopMax : req;
      if (weight == CMD_WEIGHT) begin
         for (int i = 0; i < WtCount; i++) begin
            if (WT_RANGES[i].top <= req_c) begin
               found = 1'b1;
               e     = WT_RANGES[i];
            end
         end
      end else begin
         for (int i = 0; i < EpCount; i++) begin
            if (EP_RANGES[i].top <= req_c) begin
               found = 1'b1;
               e     = EP_RANGES[i];
            end
         end
      end
      r.weight  = weight;
      r.invalid = !found || (q > e.top);
      r.q       = q;
      r.top     = e.top;
      r.kind    = e.kind;
      r.nbits   = e.nbits;
      return r;
   endfunction

   // bit replication to 8 bits (endpoint) or 6 bits (weight)
   function automatic logic [7:0] replicate_bits(logic weight, logic [3:0] n, logic [7:0] v);
      logic [7:0] r;
      r = '0;
      if (weight == CMD_WEIGHT) begin
         unique case (n)
            4'd1:    r = {2'b00, {6{v[0]}}};
            4'd2:    r = {2'b00, {3{v[1:0]}}};
            4'd3:    r = {2'b00, v[2:0], v[2:0]};
            4'd4:    r = {2'b00, v[3:0], v[3:2]};
            4'd5:    r = {2'b00, v[4:0], v[4]};
            default: r = '0;
         endcase
      end else begin
         unique case (n)
            4'd1:    r = {8{v[0]}};
            4'd2:    r = {4{v[1:0]}};
            4'd3:    r = {v[2:0], v[2:0], v[2:1]};
            4'd4:    r = {v[3:0], v[3:0]};
            4'd5:    r = {v[4:0], v[4:2]};
            4'd6:    r = {v[5:0], v[5:4]};
            4'd7:    r = {v[6:0], v[6]};
            4'd8:    r = v;
            default: r = '0;
         endcase
      end
      return r;
   endfunction

   // split the index and pick the a/b/c terms of the expansion
   function automatic dec_type decode_item(sel_type s);
      dec_type    r;
      logic [7:0] mask;
      logic [7:0] low;
      logic [8:0] x;
      logic [8:0] xs;
      logic [2:0] d;
      mask = 8'((9'h1 << s.nbits) - 9'h1);
      low  = s.q & mask;
      x    = {2'b00, low[7:1]};
      d    = 3'(s.q >> s.nbits);
      r    = '0;
      r.weight  = s.weight;
      r.invalid = s.invalid;
      r.d       = d;
      if (s.kind == KIND_BITS) begin
         r.direct     = 1'b1;
         r.direct_val = replicate_bits(s.weight, s.nbits, s.q);
      end else if (s.weight == CMD_WEIGHT) begin
         r.a = low[0] ? 9'h07F : 9'h000;
         if (s.kind == KIND_TRIT) begin
            unique case (s.top)
               8'd2: begin
                  r.direct     = 1'b1;
                  r.direct_val = WT_TRIT_DIRECT[(d < 3'd3) ? 2'(d) : 2'd2];
               end
               8'd5: r.c = 8'd50;
               8'd11: begin
                  xs  = x & 9'h001;
                  r.b = xs | (xs << 2) | (xs << 6);
                  r.c = 8'd23;
               end
               default: begin
                  xs  = x & 9'h003;
                  r.b = xs | (xs << 5);
                  r.c = 8'd11;
               end
            endcase
         end else begin
            unique case (s.top)
               8'd4: begin
                  r.direct     = 1'b1;
                  r.direct_val = WT_QUINT_DIRECT[(d < 3'd5) ? d : 3'd4];
               end
               8'd9: r.c = 8'd28;
               default: begin
                  xs  = x & 9'h001;
                  r.b = (xs << 1) | (xs << 6);
                  r.c = 8'd13;
               end
            endcase
         end
      end else begin
         r.a = low[0] ? 9'h1FF : 9'h000;
         if (s.kind == KIND_TRIT) begin
            unique case (s.top)
               8'd5: r.c = 8'd204;
               8'd11: begin
                  xs  = x & 9'h001;
                  r.b = (xs << 1) | (xs << 2) | (xs << 4) | (xs << 8);
                  r.c = 8'd93;
               end
               8'd23: begin
                  xs  = x & 9'h003;
                  r.b = xs | (xs << 2) | (xs << 7);
                  r.c = 8'd44;
               end
               8'd47: begin
                  xs  = x & 9'h007;
                  r.b = xs | (xs << 6);
                  r.c = 8'd22;
               end
               8'd95: begin
                  xs  = x & 9'h00F;
                  r.b = (xs >> 2) | (xs << 5);
                  r.c = 8'd11;
               end
               default: begin
                  xs  = x & 9'h01F;
                  r.b = (xs >> 4) | (xs << 4);
                  r.c = 8'd5;
               end
            endcase
         end else begin
            unique case (s.top)
               8'd9: r.c = 8'd113;
               8'd19: begin
                  xs  = x & 9'h001;
                  r.b = (xs << 2) | (xs << 3) | (xs << 8);
                  r.c = 8'd54;
               end
               8'd39: begin
                  xs  = x & 9'h003;
                  r.b = (xs >> 1) | (xs << 1) | (xs << 7);
                  r.c = 8'd26;
               end
               8'd79: begin
                  xs  = x & 9'h007;
                  r.b = (xs >> 1) | (xs << 6);
                  r.c = 8'd13;
               end
               default: begin
                  xs  = x & 9'h00F;
                  r.b = (xs >> 3) | (xs << 5);
                  r.c = 8'd6;
               end
            endcase
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

>>> sv/astcuq_select.sv
// stage 1: picks the supported range and flags out-of-range indexes
// depends on astcuq_pkg
`timescale 1ns / 1ps
`default_nettype none

module astcuq_select
   import astcuq_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       advance,
   input  wire logic       in_valid,
   input  wire logic       in_cmd,
   input  wire logic [7:0] in_range_max,
   input  wire logic [7:0] in_quantized,
   output logic            out_valid,
   output sel_type         out_sel
);

   logic    valid_ff;
   sel_type sel_ff;
   sel_type sel_in;

   // range lookup over the constant table
   assign sel_in = select_range(in_cmd, in_range_max, in_quantized);

   // stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
      if (advance) begin
         sel_ff <= sel_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_sel   = sel_ff;

endmodule

`default_nettype wire

>>> sv/astcuq_decode.sv
// stage 2: splits the index, replicates plain bits, picks the a/b/c terms
// depends on astcuq_pkg
`timescale 1ns / 1ps
`default_nettype none

module astcuq_decode
   import astcuq_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    advance,
   input  wire logic    in_valid,
   input  wire sel_type in_sel,
   output logic         out_valid,
   output dec_type      out_dec
);

   logic    valid_ff;
   dec_type dec_ff;
   dec_type dec_in;

   // digit split and term selection
   assign dec_in = decode_item(in_sel);

   // stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
      if (advance) begin
         dec_ff <= dec_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_dec   = dec_ff;

endmodule

`default_nettype wire

>>> sv/astcuq_expand.sv
// stage 3: the d * c + b multiply-add, xor with a and bit unshuffle
// depends on astcuq_pkg
`timescale 1ns / 1ps
`default_nettype none

module astcuq_expand
   import astcuq_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    advance,
   input  wire logic    in_valid,
   input  wire dec_type in_dec,
   output logic         out_valid,
   output mid_type      out_mid
);

   logic        valid_ff;
   mid_type     mid_ff;
   mid_type     mid_in;
   logic [10:0] sum;
   logic [8:0]  t9;
   logic [6:0]  t7;
   logic [7:0]  ep_val;
   logic [7:0]  wt_val;

   // multiply-add, then the endpoint and weight forms of the unshuffle
   always_comb begin
      sum    = 11'(in_dec.d) * 11'(in_dec.c) + 11'(in_dec.b);
      t9     = sum[8:0] ^ in_dec.a;
      t7     = sum[6:0] ^ in_dec.a[6:0];
      ep_val = {in_dec.a[7], t9[8:2]};
      wt_val = {2'b00, in_dec.a[5], t7[6:2]};
      mid_in.weight  = in_dec.weight;
      mid_in.invalid = in_dec.invalid;
      if (in_dec.direct) begin
         mid_in.value = in_dec.direct_val;
      end else if (in_dec.weight == CMD_WEIGHT) begin
         mid_in.value = wt_val;
      end else begin
         mid_in.value = ep_val;
      end
   end

   // stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
      if (advance) begin
         mid_ff <= mid_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_mid   = mid_ff;

endmodule

`default_nettype wire

>>> sv/astc_unquantize_endpoint_weight_top.sv
// pipeline: four register stages (select, decode, expand, output), passed by each item in that order
// throughput: one item per cycle unless the output stalls; all four stages move together
// a stalled valid result holds the whole pipeline and stalls the input in the same cycle
// reset: synchronous, active high, clears the stage valid bits; payload registers keep data
// top level of the astc endpoint and weight unquantizer; depends on astcuq_pkg
`timescale 1ns / 1ps
`default_nettype none

module astc_unquantize_endpoint_weight_top
   import astcuq_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic       req_cmd,
   input  wire logic [7:0] req_range_max,
   input  wire logic [7:0] req_quantized,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_result,
   output logic            rsp_invalid
);

   logic       advance;
   logic       sel_valid;
   sel_type    sel;
   logic       dec_valid;
   dec_type    dec;
   logic       mid_valid;
   mid_type    mid;
   logic       rsp_valid_ff;
   logic [7:0] rsp_result_ff;
   logic       rsp_invalid_ff;
   logic [7:0] result_in;

   // pipeline moves unless a finished item waits at a stalled output
   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;

   astcuq_select u_select (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .in_valid     (req_valid),
      .in_cmd       (req_cmd),
      .in_range_max (req_range_max),
      .in_quantized (req_quantized),
      .out_valid    (sel_valid),
      .out_sel      (sel)
   );

   astcuq_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (sel_valid),
      .in_sel    (sel),
      .out_valid (dec_valid),
      .out_dec   (dec)
   );

   astcuq_expand u_expand (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (dec_valid),
      .in_dec    (dec),
      .out_valid (mid_valid),
      .out_mid   (mid)
   );

   // weights above 32 step up by one; a flagged item reads as zero
   always_comb begin
      if (mid.invalid) begin
         result_in = '0;
      end else if (mid.weight == CMD_WEIGHT && mid.value > 8'd32) begin
         result_in = mid.value + 8'd1;
      end else begin
         result_in = mid.value;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= mid_valid;
      end
      if (advance) begin
         rsp_result_ff  <= result_in;
         rsp_invalid_ff <= mid.invalid;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_result  = rsp_result_ff;
   assign rsp_invalid = rsp_invalid_ff;

endmodule

`default_nettype wire

>>> sv/astcuq_checker.sv
// port-level checks for the astc unquantize top level, attached by bind
// depends on astc_unquantize_endpoint_weight_top_defines.svh
`timescale 1ns / 1ps
`default_nettype none

`include "astc_unquantize_endpoint_weight_top_defines.svh"

module astcuq_port_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_stall,
   input wire logic       req_cmd,
   input wire logic [7:0] req_range_max,
   input wire logic [7:0] req_quantized,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [7:0] rsp_result,
   input wire logic       rsp_invalid
);

   // a stalled item on the input stays in place
   `ASTCUQ_ASSERT_NEXT(a_req_hold, clock, reset,
      req_valid && req_stall,
      req_valid && $stable({req_cmd, req_range_max, req_quantized}),
      "stalled item changed")

   // a stalled result stays in place
   `ASTCUQ_ASSERT_NEXT(a_rsp_hold, clock, reset,
      rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_result) && $stable(rsp_invalid),
      "stalled result changed")

   // a flagged item carries a zero value
   `ASTCUQ_ASSERT_IMPLY(a_invalid_zero, clock, reset,
      rsp_valid && rsp_invalid,
      rsp_result == 8'd0,
      "flagged item with nonzero result")

   // input is held exactly while a result waits at a stalled output
   `ASTCUQ_ASSERT_IMPLY(a_stall_link, clock, reset,
      1'b1,
      req_stall == (rsp_valid && rsp_stall),
      "input stall does not follow output stall")

endmodule

bind astc_unquantize_endpoint_weight_top astcuq_port_checker u_checker (.*);

`default_nettype wire
